### sv/rv64i_subset_execute_step_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RV64I execute step unit
// Define NO_ASSERTIONS to compile them away.
// ---------------------------------------------------------------------------
`ifndef RV64I_SUBSET_EXECUTE_STEP_UNIT_ASSERT_SVH
`define RV64I_SUBSET_EXECUTE_STEP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RVX_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RVX_ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define RVX_ASSERT_ALWAYS(label, cond, msg)
`define RVX_ASSERT_IMPLIES(label, pre, post, msg)
`endif
`endif

### sv/rvx_pkg.sv
// ---------------------------------------------------------------------------
// rvx_pkg
// Types and constants shared by the RV64I execute step unit.
// ---------------------------------------------------------------------------
package rvx_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] F6_BASE = 6'h00;
    localparam logic [5:0] F6_SRA  = 6'h10;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] instruction;
        logic [13:0] preload_address;
        logic [7:0]  preload_byte;
    } req_t;

    typedef struct packed {
        logic [63:0] next_pc;
        logic [4:0]  dest_index;
        logic [63:0] dest_value;
        logic        dest_written;
        logic        memory_written;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] npc;
        logic        rd_we;
        logic [63:0] value;
        logic        load;
        logic        mem_we;
        logic [63:0] addr;
        logic [1:0]  size;
        logic        uns;
        logic [31:0] wdata;
    } exec_t;

endpackage

### sv/rvx_ram.sv
// ---------------------------------------------------------------------------
// rvx_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module rvx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/rvx_exec.sv
// ---------------------------------------------------------------------------
// rvx_exec
// Decode, ALU, branch and address generation for one request.
// ---------------------------------------------------------------------------
module rvx_exec #(
    parameter int MEM_BYTES = 16384
) (
    input  rvx_pkg::req_t  req,
    input  logic [63:0]    pc,
    input  logic [63:0]    a,
    input  logic [63:0]    b,
    output rvx_pkg::exec_t ex
);

    always_comb
    begin
        logic [31:0] ins;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [5:0]  sh;
        logic [63:0] immi;
        logic [63:0] imms;
        logic [63:0] immu;
        logic [63:0] offj;
        logic [63:0] offb;
        logic [63:0] lim;
        logic        taken;

        ins   = req.instruction;
        opc   = ins[6:0];
        f3    = ins[14:12];
        f7    = ins[31:25];
        sh    = ins[25:20];
        immi  = {{52{ins[31]}}, ins[31:20]};
        imms  = {{52{ins[31]}}, ins[31:25], ins[11:7]};
        immu  = {{32{ins[31]}}, ins[31:12], 12'b0};
        offj  = {{44{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
        offb  = {{52{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
        taken = 1'b0;

        ex.status = rvx_pkg::ST_OK;
        ex.npc    = pc + 64'd4;
        ex.rd_we  = 1'b0;
        ex.value  = '0;
        ex.load   = 1'b0;
        ex.mem_we = 1'b0;
        ex.addr   = a + immi;
        ex.size   = f3[1:0];
        ex.uns    = f3[2];
        ex.wdata  = b[31:0];
        lim       = 64'(MEM_BYTES) - (64'd1 << f3[1:0]);

        if (req.cmd)
        begin
            ex.npc   = pc;
            ex.addr  = {50'b0, req.preload_address};
            ex.size  = 2'd0;
            ex.wdata = {24'b0, req.preload_byte};
            if (ex.addr < 64'(MEM_BYTES))
            begin
                ex.mem_we = 1'b1;
            end
            else
            begin
                ex.status = rvx_pkg::ST_RANGE;
            end
        end
        else
        begin
            case (opc)
                rvx_pkg::OPC_LUI:
                begin
                    ex.value = immu;
                    ex.rd_we = 1'b1;
                end
                rvx_pkg::OPC_AUIPC:
                begin
                    ex.value = pc + immu;
                    ex.rd_we = 1'b1;
                end
                rvx_pkg::OPC_JAL:
                begin
                    ex.value = pc + 64'd4;
                    ex.rd_we = 1'b1;
                    ex.npc   = pc + offj;
                end
                rvx_pkg::OPC_JALR:
                begin
                    if (f3 != 3'd0)
                    begin
                        ex.status = rvx_pkg::ST_ILLEGAL;
                    end
                    ex.value = pc + 64'd4;
                    ex.rd_we = 1'b1;
                    ex.npc   = {ex.addr[63:1], 1'b0};
                end
                rvx_pkg::OPC_BRANCH:
                begin
                    case (f3)
                        3'd0:    taken = (a == b);
                        3'd1:    taken = (a != b);
                        3'd4:    taken = ($signed(a) < $signed(b));
                        3'd5:    taken = !($signed(a) < $signed(b));
                        3'd6:    taken = (a < b);
                        3'd7:    taken = (a >= b);
                        default: ex.status = rvx_pkg::ST_ILLEGAL;
                    endcase
                    if (taken)
                    begin
                        ex.npc = pc + offb;
                    end
                end
                rvx_pkg::OPC_LOAD:
                begin
                    if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7)
                    begin
                        ex.status = rvx_pkg::ST_ILLEGAL;
                    end
                    else if (ex.addr > lim)
                    begin
                        ex.status = rvx_pkg::ST_RANGE;
                    end
                    ex.load  = 1'b1;
                    ex.rd_we = 1'b1;
                end
                rvx_pkg::OPC_STORE:
                begin
                    ex.addr = a + imms;
                    if (f3 > 3'd2)
                    begin
                        ex.status = rvx_pkg::ST_ILLEGAL;
                    end
                    else if (ex.addr > lim)
                    begin
                        ex.status = rvx_pkg::ST_RANGE;
                    end
                    ex.mem_we = 1'b1;
                end
                rvx_pkg::OPC_OPIMM:
                begin
                    ex.rd_we = 1'b1;
                    case (f3)
                        3'd0: ex.value = ex.addr;
                        3'd2: ex.value = {63'b0, ($signed(a) < $signed(immi))};
                        3'd3: ex.value = {63'b0, (a < immi)};
                        3'd4: ex.value = a ^ immi;
                        3'd6: ex.value = a | immi;
                        3'd7: ex.value = a & immi;
                        3'd1:
                        begin
                            if (ins[31:26] != rvx_pkg::F6_BASE)
                            begin
                                ex.status = rvx_pkg::ST_ILLEGAL;
                            end
                            ex.value = a << sh;
                        end
                        default:
                        begin
                            if (ins[31:26] == rvx_pkg::F6_BASE)
                            begin
                                ex.value = a >> sh;
                            end
                            else if (ins[31:26] == rvx_pkg::F6_SRA)
                            begin
                                ex.value = 64'($signed(a) >>> sh);
                            end
                            else
                            begin
                                ex.status = rvx_pkg::ST_ILLEGAL;
                            end
                        end
                    endcase
                end
                rvx_pkg::OPC_OP:
                begin
                    ex.rd_we = 1'b1;
                    if (f7 == rvx_pkg::F7_BASE && f3 == 3'd0)
                    begin
                        ex.value = a + b;
                    end
                    else if (f7 == rvx_pkg::F7_ALT && f3 == 3'd0)
                    begin
                        ex.value = a - b;
                    end
                    else if (f7 == rvx_pkg::F7_BASE && f3 == 3'd6)
                    begin
                        ex.value = a | b;
                    end
                    else if (f7 == rvx_pkg::F7_BASE && f3 == 3'd7)
                    begin
                        ex.value = a & b;
                    end
                    else
                    begin
                        ex.status = rvx_pkg::ST_ILLEGAL;
                    end
                end
                default:
                begin
                    ex.status = rvx_pkg::ST_ILLEGAL;
                end
            endcase
        end

        if (ex.status != rvx_pkg::ST_OK)
        begin
            ex.npc    = pc;
            ex.rd_we  = 1'b0;
            ex.mem_we = 1'b0;
            ex.load   = 1'b0;
        end
    end

endmodule

### sv/rv64i_subset_execute_step_unit.sv
// ---------------------------------------------------------------------------
// rv64i_subset_execute_step_unit
// Executes one RV64I instruction or one memory preload per request.
// ---------------------------------------------------------------------------
// Register file and data memory live in registered-read RAMs (two copies of
// the register file for rs1/rs2, four byte banks for data). A request is
// accepted, its operands read on that edge, and it executes in the following
// cycle; the response is registered when it leaves execute. Non-load requests
// and preloads sustain one per cycle while responses are taken. A load waits on
// the data bank read in a write-back stage, so the request behind it waits in
// execute and the load's response is registered from that stage. Writes that
// land on the same edge as an operand read are forwarded. Writing cfg_data
// loads the program counter.
module rv64i_subset_execute_step_unit #(
    parameter int MEM_BYTES = 16384
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rvx_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rvx_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [63:0]   cfg_data
);

`include "rv64i_subset_execute_step_unit_assert.svh"

    localparam int BANK_DEPTH = (MEM_BYTES + 3) / 4;
    localparam int RW         = $clog2(BANK_DEPTH);

    logic                      e_valid_reg;
    rvx_pkg::req_t             e_req_reg;
    logic [63:0]               pc_reg;
    logic                      w_valid_reg;
    logic [4:0]                w_rd_reg;
    logic [63:0]               w_npc_reg;
    logic [1:0]                w_lo_reg;
    logic [1:0]                w_size_reg;
    logic                      w_uns_reg;
    logic [RW-1:0]             w_rows_reg [4];
    logic                      out_valid_reg;
    rvx_pkg::rsp_t             out_reg;
    logic                      fwd_valid_reg;
    logic [4:0]                fwd_idx_reg;
    logic [63:0]               fwd_val_reg;
    logic [rvx_pkg::REG_COUNT-1:0] rf_valid_reg;

    rvx_pkg::exec_t            ex;
    logic                      accept;
    logic                      out_free;
    logic                      e_done;
    logic                      w_done;
    logic [4:0]                rs1;
    logic [4:0]                rs2;
    logic [4:0]                rs1_rd;
    logic [4:0]                rs2_rd;
    logic [4:0]                e_rd;
    logic [63:0]               rf_rdata1;
    logic [63:0]               rf_rdata2;
    logic [63:0]               op_a;
    logic [63:0]               op_b;
    logic                      rf_we;
    logic [4:0]                rf_waddr;
    logic [63:0]               rf_wdata;
    logic [63:0]               load_val;
    logic [31:0]               load_raw;
    logic [RW-1:0]             lane_row [4];
    logic [RW-1:0]             lane_raddr [4];
    logic                      lane_we [4];
    logic [7:0]                lane_wd [4];
    logic [7:0]                lane_rd [4];
    logic                      e_writes_rd;
    rvx_pkg::rsp_t             e_rsp;

    assign rs1      = e_req_reg.instruction[19:15];
    assign rs2      = e_req_reg.instruction[24:20];
    assign e_rd     = e_req_reg.instruction[11:7];
    assign out_free = !out_valid_reg || rsp_ready;
    assign e_done   = e_valid_reg && !w_valid_reg && (ex.load || out_free);
    assign w_done   = w_valid_reg && out_free;
    assign req_ready = !e_valid_reg || e_done;
    assign accept   = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp      = out_reg;

    // operands are re-read every cycle; only a same-edge write needs forwarding
    assign rs1_rd = accept ? req.instruction[19:15] : rs1;
    assign rs2_rd = accept ? req.instruction[24:20] : rs2;

    always_comb
    begin
        if (fwd_valid_reg && fwd_idx_reg == rs1)
        begin
            op_a = fwd_val_reg;
        end
        else
        begin
            op_a = rf_valid_reg[rs1] ? rf_rdata1 : '0;
        end
        if (fwd_valid_reg && fwd_idx_reg == rs2)
        begin
            op_b = fwd_val_reg;
        end
        else
        begin
            op_b = rf_valid_reg[rs2] ? rf_rdata2 : '0;
        end
    end

    rvx_ram #(.WIDTH(64), .DEPTH(rvx_pkg::REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rs1_rd),
        .rdata (rf_rdata1)
    );

    rvx_ram #(.WIDTH(64), .DEPTH(rvx_pkg::REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rs2_rd),
        .rdata (rf_rdata2)
    );

    rvx_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
        .req (e_req_reg),
        .pc  (pc_reg),
        .a   (op_a),
        .b   (op_b),
        .ex  (ex)
    );

    // byte k of an access goes to bank (addr + k) mod 4
    for (genvar l = 0; l < 4; l++)
    begin : g_bank
        logic [1:0]    k;
        logic [RW+1:0] baddr;

        assign k        = 2'(l) - ex.addr[1:0];
        assign baddr    = ex.addr[RW+1:0] + (RW+2)'(k);
        assign lane_row[l]   = baddr[RW+1:2];
        assign lane_we[l]    = e_done && ex.mem_we && ({1'b0, k} < (3'd1 << ex.size));
        assign lane_wd[l]    = ex.wdata[8*k +: 8];
        assign lane_raddr[l] = w_valid_reg ? w_rows_reg[l] : lane_row[l];

        rvx_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank (
            .clk   (clk),
            .we    (lane_we[l]),
            .waddr (lane_row[l]),
            .wdata (lane_wd[l]),
            .raddr (lane_raddr[l]),
            .rdata (lane_rd[l])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            load_raw[8*k +: 8] = lane_rd[w_lo_reg + 2'(k)];
        end
        case (w_size_reg)
            2'd0:    load_val = {{56{load_raw[7]  && !w_uns_reg}}, load_raw[7:0]};
            2'd1:    load_val = {{48{load_raw[15] && !w_uns_reg}}, load_raw[15:0]};
            default: load_val = {{32{load_raw[31] && !w_uns_reg}}, load_raw};
        endcase
    end

    assign e_writes_rd = ex.rd_we && !ex.load && (e_rd != '0);

    always_comb
    begin
        if (w_done)
        begin
            rf_we    = (w_rd_reg != '0);
            rf_waddr = w_rd_reg;
            rf_wdata = load_val;
        end
        else
        begin
            rf_we    = e_done && e_writes_rd;
            rf_waddr = e_rd;
            rf_wdata = ex.value;
        end
    end

    always_comb
    begin
        e_rsp.next_pc        = ex.npc;
        e_rsp.dest_index     = e_writes_rd ? e_rd : '0;
        e_rsp.dest_value     = e_writes_rd ? ex.value : '0;
        e_rsp.dest_written   = e_writes_rd;
        e_rsp.memory_written = ex.mem_we;
        e_rsp.status         = ex.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
            pc_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_done)
            begin
                e_valid_reg <= 1'b0;
            end

            if (e_done && ex.load)
            begin
                w_valid_reg <= 1'b1;
            end
            else if (w_done)
            begin
                w_valid_reg <= 1'b0;
            end

            if (w_done || (e_done && !ex.load))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            fwd_valid_reg <= rf_we;
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end

            if (cfg_valid)
            begin
                pc_reg <= cfg_data;
            end
            else if (e_done)
            begin
                pc_reg <= ex.npc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_req_reg <= req;
        end
        fwd_idx_reg <= rf_waddr;
        fwd_val_reg <= rf_wdata;
        if (e_done && ex.load)
        begin
            w_rd_reg   <= e_rd;
            w_npc_reg  <= ex.npc;
            w_lo_reg   <= ex.addr[1:0];
            w_size_reg <= ex.size;
            w_uns_reg  <= ex.uns;
            for (int l = 0; l < 4; l++)
            begin
                w_rows_reg[l] <= lane_row[l];
            end
        end
        if (w_done)
        begin
            out_reg.next_pc        <= w_npc_reg;
            out_reg.dest_index     <= w_rd_reg;
            out_reg.dest_value     <= (w_rd_reg != '0) ? load_val : '0;
            out_reg.dest_written   <= (w_rd_reg != '0);
            out_reg.memory_written <= 1'b0;
            out_reg.status         <= rvx_pkg::ST_OK;
        end
        else if (e_done && !ex.load)
        begin
            out_reg <= e_rsp;
        end
    end

    `RVX_ASSERT_IMPLIES(a_no_x0_write, rf_we, rf_waddr != '0, "write to x0")
    `RVX_ASSERT_IMPLIES(a_e_holds_for_w, w_valid_reg, !e_done, "execute retired under load")
    `RVX_ASSERT_IMPLIES(a_no_overwrite, accept && e_valid_reg, e_done,
        "request overwritten in execute")
    `RVX_ASSERT_ALWAYS(a_one_result, !(w_done && e_done), "two results in one cycle")

endmodule
